[sv/pps_pkg.sv]
// Package for the preemptive priority scheduler: sizes, status codes, types.
// Used by every module of the block; depends on nothing.
package pps_pkg;

  localparam int Slots = 16;
  localparam int SlotW = $clog2(Slots);
  // Scan counter width: one extra bit so the count can reach Slots.
  localparam int CntW  = SlotW + 1;

  typedef logic [SlotW-1:0] slot_idx_t;

  typedef enum logic [2:0] {
    ST_ADMITTED   = 3'd0,
    ST_FULL       = 3'd1,
    ST_ZERO_BURST = 3'd2,
    ST_IDLE       = 3'd3,
    ST_RAN        = 3'd4,
    ST_DONE       = 3'd5
  } status_t;

  // One decoded input word as it waits in the queue.
  typedef struct packed {
    logic        mode;
    logic [7:0]  process_id;
    logic [7:0]  priority_req;
    logic [15:0] burst_time;
  } item_t;

  // One result word.
  typedef struct packed {
    status_t     status;
    logic [7:0]  ran_id;
    logic [31:0] finish_time;
    logic [31:0] turnaround_time;
    logic [31:0] waiting_time;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_EXEC,
    S_OUT
  } exec_state_t;

endpackage

[sv/pps_front.sv]
// Front end: accepts input words and holds them in a two-entry queue.
// Depends on pps_pkg.
module pps_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pps_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_ready,
  output pps_pkg::item_t q_item
);

  pps_pkg::item_t fifo [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = fifo[rptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= in_item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[sv/pps_exec.sv]
// Back end: slot table, one-slot-per-cycle winner scan and result register.
// Depends on pps_pkg.
module pps_exec (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  pps_pkg::item_t   q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output pps_pkg::result_t out_res
);

  pps_pkg::exec_state_t state, state_next;

  logic [pps_pkg::Slots-1:0] slot_valid;
  logic [7:0]  slot_id        [pps_pkg::Slots];
  logic [7:0]  slot_priority  [pps_pkg::Slots];
  logic [31:0] slot_arrival   [pps_pkg::Slots];
  logic [15:0] slot_burst     [pps_pkg::Slots];
  logic [15:0] slot_remaining [pps_pkg::Slots];
  logic [31:0] tick_count;

  pps_pkg::item_t    cur;
  logic [pps_pkg::CntW-1:0] scan_cnt;
  pps_pkg::slot_idx_t scan_idx;
  logic              best_found;
  pps_pkg::slot_idx_t best_idx;
  logic [7:0]        best_prio;
  logic [31:0]       best_arr;
  logic              free_found;
  pps_pkg::slot_idx_t free_idx;
  logic              wins;

  // Values of the chosen slot, registered before the update.
  logic [7:0]  r_id;
  logic [31:0] r_arr;
  logic [15:0] r_burst;
  logic [15:0] r_rem;

  logic [31:0] tick_sat;
  logic [15:0] rem_dec;
  logic [31:0] tat;
  logic [31:0] wt;
  pps_pkg::result_t res_next;

  assign scan_idx = scan_cnt[pps_pkg::SlotW-1:0];
  assign q_ready  = (state == pps_pkg::S_IDLE);
  assign out_valid = (state == pps_pkg::S_OUT);

  // Lower priority wins, then earlier arrival; lower index wins by scan order.
  assign wins = !best_found ||
                (slot_priority[scan_idx] < best_prio) ||
                (slot_priority[scan_idx] == best_prio && slot_arrival[scan_idx] < best_arr);

  assign tick_sat = (tick_count == 32'hFFFF_FFFF) ? tick_count : tick_count + 32'd1;
  assign rem_dec  = (r_rem != 16'd0) ? r_rem - 16'd1 : 16'd0;
  assign tat      = tick_sat - r_arr;
  assign wt       = (tat >= {16'd0, r_burst}) ? tat - {16'd0, r_burst} : 32'd0;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pps_pkg::S_IDLE: begin
        if (q_valid) begin
          state_next = pps_pkg::S_SCAN;
        end
      end
      pps_pkg::S_SCAN: begin
        if (scan_cnt == pps_pkg::CntW'(pps_pkg::Slots - 1)) begin
          state_next = pps_pkg::S_READ;
        end
      end
      pps_pkg::S_READ: state_next = pps_pkg::S_EXEC;
      pps_pkg::S_EXEC: state_next = pps_pkg::S_OUT;
      pps_pkg::S_OUT: begin
        if (out_ready) begin
          state_next = pps_pkg::S_IDLE;
        end
      end
      default: state_next = pps_pkg::S_IDLE;
    endcase
  end

  // Scan over the slots, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt   <= '0;
      best_found <= 1'b0;
      free_found <= 1'b0;
    end else if (state == pps_pkg::S_IDLE) begin
      scan_cnt   <= '0;
      best_found <= 1'b0;
      free_found <= 1'b0;
      if (q_valid) begin
        cur <= q_item;
      end
    end else if (state == pps_pkg::S_SCAN) begin
      scan_cnt <= scan_cnt + pps_pkg::CntW'(1);
      if (slot_valid[scan_idx] && wins) begin
        best_found <= 1'b1;
        best_idx   <= scan_idx;
        best_prio  <= slot_priority[scan_idx];
        best_arr   <= slot_arrival[scan_idx];
      end
      if (!slot_valid[scan_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= scan_idx;
      end
    end
  end

  // Fetch the winner's fields.
  always_ff @(posedge clk) begin
    if (state == pps_pkg::S_READ) begin
      r_id    <= slot_id[best_idx];
      r_arr   <= slot_arrival[best_idx];
      r_burst <= slot_burst[best_idx];
      r_rem   <= slot_remaining[best_idx];
    end
  end

  // Slot payload writes.
  always_ff @(posedge clk) begin
    if (state == pps_pkg::S_EXEC) begin
      if (!cur.mode) begin
        if (cur.burst_time != 16'd0 && free_found) begin
          slot_id[free_idx]        <= cur.process_id;
          slot_priority[free_idx]  <= cur.priority_req;
          slot_arrival[free_idx]   <= tick_count;
          slot_burst[free_idx]     <= cur.burst_time;
          slot_remaining[free_idx] <= cur.burst_time;
        end
      end else if (best_found) begin
        slot_remaining[best_idx] <= rem_dec;
      end
    end
  end

  // Result of the current word.
  always_comb begin
    res_next        = '0;
    res_next.status = pps_pkg::ST_IDLE;
    if (!cur.mode) begin
      if (cur.burst_time == 16'd0) begin
        res_next.status = pps_pkg::ST_ZERO_BURST;
      end else if (!free_found) begin
        res_next.status = pps_pkg::ST_FULL;
      end else begin
        res_next.status = pps_pkg::ST_ADMITTED;
        res_next.ran_id = cur.process_id;
      end
    end else if (best_found) begin
      res_next.ran_id = r_id;
      if (rem_dec != 16'd0) begin
        res_next.status = pps_pkg::ST_RAN;
      end else begin
        res_next.status          = pps_pkg::ST_DONE;
        res_next.finish_time     = tick_sat;
        res_next.turnaround_time = tat;
        res_next.waiting_time    = wt;
      end
    end
  end

  // Valid bits and tick counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      tick_count <= 32'd0;
    end else if (state == pps_pkg::S_EXEC) begin
      if (!cur.mode) begin
        if (cur.burst_time != 16'd0 && free_found) begin
          slot_valid[free_idx] <= 1'b1;
        end
      end else begin
        tick_count <= tick_sat;
        if (best_found && rem_dec == 16'd0) begin
          slot_valid[best_idx] <= 1'b0;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state == pps_pkg::S_EXEC) begin
      out_res <= res_next;
    end
  end

endmodule

[sv/preemptive_priority_scheduler_unit.sv]
// Top level of the preemptive priority scheduler: input queue and executor.
// Depends on pps_pkg, pps_front and pps_exec.
//
//  channel | dir | fields (low bit first)
//  s_axis  | in  | tdata: mode, process_id, priority_req, burst_time (33 bits, pad to 40)
//  m_axis  | out | tdata: status, ran_id, finish_time, turnaround_time,
//          |     |        waiting_time (107 bits, pad to 112)
//
// The executor takes one word at a time: a one-slot-per-cycle scan of all slots, then read, execute and output.
// The two-entry front queue takes up to two words while the executor works or stalls.
// A word's result waits in the result register until m_axis_tready.
// Reset is synchronous; it clears all slots and the tick counter.
module preemptive_priority_scheduler_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // mode, process_id, priority_req, burst_time
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata   // status, ran_id, finish, turnaround, waiting
);

  pps_pkg::item_t   in_item;
  pps_pkg::item_t   q_item;
  pps_pkg::result_t res;
  logic             q_valid;
  logic             q_ready;

  // Unpack the input word.
  assign in_item.mode         = s_axis_tdata[0];
  assign in_item.process_id   = s_axis_tdata[8:1];
  assign in_item.priority_req = s_axis_tdata[16:9];
  assign in_item.burst_time   = s_axis_tdata[32:17];

  pps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  pps_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  // Pack the result word.
  assign m_axis_tdata = {5'd0, res.waiting_time, res.turnaround_time, res.finish_time,
                         res.ran_id, res.status};

endmodule

[sv/pps_checker.sv]
// Port checks for the preemptive priority scheduler, bound to the top level.
// Depends on pps_pkg and the top level's port list.
module pps_port_checks (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata
);

  // A stalled result word holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The status code never goes beyond finished.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= pps_pkg::ST_DONE)
    else $error("bad status code");

  // Times are zero unless the process finished.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] != pps_pkg::ST_DONE |-> m_axis_tdata[106:11] == 96'd0)
    else $error("times set without finish");

  // Nothing comes out in the cycle after reset.
  assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result right after reset");

  // No result can follow an accepted result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("results back to back");

endmodule

bind preemptive_priority_scheduler_unit pps_port_checks u_pps_port_checks (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/pps_checker.sv]
// Checker for the preemptive priority scheduler: watches both stream channels,
// predicts each result word from accepted input words and compares field by field.
// Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [111:0] m_axis_tdata,
  output int           fail_count,
  output int           pending
);

  // Shadow copy of the process table.
  logic        tbl_valid [pps_pkg::Slots];
  logic [7:0]  tbl_id    [pps_pkg::Slots];
  logic [7:0]  tbl_prio  [pps_pkg::Slots];
  logic [31:0] tbl_arr   [pps_pkg::Slots];
  logic [15:0] tbl_burst [pps_pkg::Slots];
  logic [15:0] tbl_left  [pps_pkg::Slots];
  logic [31:0] ticks;

  pps_pkg::result_t sched_results [$];

  // True if slot a is served ahead of slot b.
  function automatic bit served_first(int a, int b);
    if (tbl_prio[a] != tbl_prio[b]) return tbl_prio[a] < tbl_prio[b];
    if (tbl_arr[a] != tbl_arr[b]) return tbl_arr[a] < tbl_arr[b];
    return a < b;
  endfunction

  // Apply one input word to the shadow table and return its result.
  function automatic pps_pkg::result_t schedule_word(logic [39:0] d);
    pps_pkg::result_t r;
    logic        mode;
    logic [7:0]  pid;
    logic [7:0]  prio;
    logic [15:0] burst;
    int          sel;
    logic [31:0] tat;
    mode  = d[0];
    pid   = d[8:1];
    prio  = d[16:9];
    burst = d[32:17];
    sel   = -1;
    r     = '0;
    r.status = pps_pkg::ST_ADMITTED;
    if (!mode) begin
      if (burst == 0) begin
        r.status = pps_pkg::ST_ZERO_BURST;
        return r;
      end
      for (int i = 0; i < pps_pkg::Slots; i++)
        if (!tbl_valid[i] && sel < 0) sel = i;
      if (sel < 0) begin
        r.status = pps_pkg::ST_FULL;
        return r;
      end
      tbl_valid[sel] = 1'b1;
      tbl_id[sel]    = pid;
      tbl_prio[sel]  = prio;
      tbl_arr[sel]   = ticks;
      tbl_burst[sel] = burst;
      tbl_left[sel]  = burst;
      r.ran_id = pid;
      return r;
    end
    for (int i = 0; i < pps_pkg::Slots; i++)
      if (tbl_valid[i] && (sel < 0 || served_first(i, sel))) sel = i;
    if (ticks != 32'hFFFF_FFFF) ticks = ticks + 1;
    if (sel < 0) begin
      r.status = pps_pkg::ST_IDLE;
      return r;
    end
    r.ran_id = tbl_id[sel];
    if (tbl_left[sel] != 0) tbl_left[sel] = tbl_left[sel] - 1;
    if (tbl_left[sel] != 0) begin
      r.status = pps_pkg::ST_RAN;
      return r;
    end
    tat = ticks - tbl_arr[sel];
    r.status          = pps_pkg::ST_DONE;
    r.finish_time     = ticks;
    r.turnaround_time = tat;
    r.waiting_time    = (tat >= tbl_burst[sel]) ? tat - tbl_burst[sel] : 32'd0;
    tbl_valid[sel] = 1'b0;
    return r;
  endfunction

  // Predict on input handshakes, compare on output handshakes.
  always @(posedge clk) begin
    pps_pkg::result_t want;
    pps_pkg::result_t got;
    if (rst) begin
      for (int i = 0; i < pps_pkg::Slots; i++) tbl_valid[i] = 1'b0;
      ticks = '0;
      fail_count = 0;
      sched_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = schedule_word(s_axis_tdata);
        sched_results.insert(sched_results.size(), want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status          = pps_pkg::status_t'(m_axis_tdata[2:0]);
        got.ran_id          = m_axis_tdata[10:3];
        got.finish_time     = m_axis_tdata[42:11];
        got.turnaround_time = m_axis_tdata[74:43];
        got.waiting_time    = m_axis_tdata[106:75];
        if (sched_results.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, m_axis_tdata);
          fail_count++;
        end else begin
          want = sched_results.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fail_count++;
          end
          if (got.ran_id != want.ran_id) begin
            $display("%0t: ran_id expected %0d actual %0d", $time, want.ran_id, got.ran_id);
            fail_count++;
          end
          if (got.finish_time != want.finish_time) begin
            $display("%0t: finish_time expected %0d actual %0d", $time,
                     want.finish_time, got.finish_time);
            fail_count++;
          end
          if (got.turnaround_time != want.turnaround_time) begin
            $display("%0t: turnaround_time expected %0d actual %0d", $time,
                     want.turnaround_time, got.turnaround_time);
            fail_count++;
          end
          if (got.waiting_time != want.waiting_time) begin
            $display("%0t: waiting_time expected %0d actual %0d", $time,
                     want.waiting_time, got.waiting_time);
            fail_count++;
          end
        end
      end
    end
    pending = sched_results.size();
  end

endmodule

[tb/tb.sv]
// Top of the scheduler testbench: clock, reset, stimulus, sink stalls and verdict.
// Depends on pps_checker and preemptive_priority_scheduler_unit.
`timescale 1ns / 1ps

module tb;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  int           fail_count;
  int           pending;
  int           cycles = 0;
  bit           no_gaps = 1'b0;

  localparam logic MODE_ADMIT = 1'b0;
  localparam logic MODE_TICK  = 1'b1;
  localparam int   CycleLimit = 400000;

  always #10 clk = ~clk;

  preemptive_priority_scheduler_unit dut (.*);

  pps_checker chk (.*);

  // Run-away guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Sink: random stalls before taking each word, none in quiet stretches.
  initial begin
    int w;
    @(posedge clk iff !rst);
    forever begin
      w = no_gaps ? 0 : $urandom_range(0, 14);
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk iff m_axis_tvalid);
    end
  end

  // Send one word after a random gap.
  task automatic send_word(logic mode, logic [7:0] pid, logic [7:0] prio,
                           logic [15:0] burst);
    int w;
    w = no_gaps ? 0 : $urandom_range(0, 14);
    if (w > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, burst, prio, pid, mode};
    @(posedge clk iff s_axis_tready);
  endtask

  task automatic admit(logic [7:0] pid, logic [7:0] prio, logic [15:0] burst);
    send_word(MODE_ADMIT, pid, prio, burst);
  endtask

  task automatic tick();
    send_word(MODE_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  initial begin
    int sent;
    int k;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle tick, zero burst, extremes, ties, fill to full, then two ticks.
    tick();
    admit(8'hFF, 8'h00, 16'd0);
    admit(8'h00, 8'hFF, 16'hFFFF);
    admit(8'hFF, 8'h00, 16'd1);
    admit(8'h5A, 8'h00, 16'd2);
    tick();
    tick();
    admit(8'hA5, 8'h00, 16'd1);
    tick();
    tick();
    for (int i = 0; i < 16; i++) admit(8'(i), 8'h80, 16'd1);
    admit(8'h77, 8'h01, 16'd3);
    admit(8'h78, 8'h01, 16'd0);
    tick();
    tick();

    // Random: mostly ticks and admits with small bursts, some long ones.
    sent = 0;
    while (sent < 600) begin
      if (sent % 100 == 50) no_gaps = 1'b1;
      if (sent % 100 == 80) no_gaps = 1'b0;
      k = $urandom_range(0, 99);
      if (k < 50) tick();
      else if (k < 55) admit(8'($urandom), 8'($urandom), 16'd0);
      else if (k < 60) admit(8'($urandom), 8'($urandom), 16'($urandom));
      else admit(8'($urandom), 8'($urandom_range(0, 7)), 16'($urandom_range(1, 6)));
      sent++;
    end
    s_axis_tvalid <= 1'b0;

    // Let the checker record the last word before waiting for the drain.
    @(posedge clk);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
